FILE: src/rmq_pkg.sv
// Shared constants, types and codes for the rotation matrix to quaternion unit.
`timescale 1ns / 1ps
package rmq_pkg;
   localparam int FRAC_BITS = 16;
   localparam int FIELD_W = 18;
   localparam int SUM_W = FIELD_W + 1;
   localparam int D_MAG_W = FIELD_W + 1;
   localparam int ARG_W = ((FRAC_BITS + 2 > FIELD_W + 2) ? FRAC_BITS + 2 : FIELD_W + 2) + 1;
   localparam int RAD_W = ARG_W - 1 + FRAC_BITS + 2;
   localparam int SQ_N = (RAD_W + 1) / 2;
   localparam int RAD2_W = 2 * SQ_N;
   localparam int REM_W = SQ_N + 3;
   localparam int S_W = SQ_N + 1;
   localparam int Q_W = FIELD_W;
   localparam int NUM_W = D_MAG_W + FRAC_BITS + 1;
   localparam int CMP_W = ((NUM_W > S_W + Q_W) ? NUM_W : S_W + Q_W) + 1;
   localparam int NST = SQ_N + Q_W + 2;
   localparam int LANES = 3;

   localparam logic signed [FIELD_W-1:0] FIELD_MAX = FIELD_W'((64'sd1 <<< (FIELD_W - 1)) - 1);
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = FIELD_W'(-(64'sd1 <<< (FIELD_W - 1)));

   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_M00   = 2'd1;
   localparam logic [1:0] BR_M11   = 2'd2;
   localparam logic [1:0] BR_M22   = 2'd3;

   typedef struct packed {
      logic [1:0]                        br;
      logic                              bad;
      logic [ARG_W-2:0]                  arg;
      logic [LANES-1:0]                  dneg;
      logic [LANES-1:0][D_MAG_W-1:0]     dmag;
   } front_word_type;

   typedef struct packed {
      logic [1:0]                        br;
      logic                              bad;
      logic [RAD2_W-1:0]                 rad;
      logic [REM_W-1:0]                  rem;
      logic [SQ_N-1:0]                   root;
      logic [S_W-1:0]                    s;
      logic [FIELD_W-1:0]                mainc;
      logic [LANES-1:0]                  dneg;
      logic [LANES-1:0][D_MAG_W-1:0]     dmag;
      logic [LANES-1:0][CMP_W-1:0]       r;
      logic [LANES-1:0][Q_W-1:0]         q;
      logic [LANES-1:0]                  ovf;
   } stage_type;
endpackage

FILE: src/rmq_front.sv
// Front end: picks the branch, forms the root argument and the three lane sums.
`timescale 1ns / 1ps
module rmq_front import rmq_pkg::*; (
   input  logic signed [FIELD_W-1:0] m00,
   input  logic signed [FIELD_W-1:0] m10,
   input  logic signed [FIELD_W-1:0] m20,
   input  logic signed [FIELD_W-1:0] m01,
   input  logic signed [FIELD_W-1:0] m11,
   input  logic signed [FIELD_W-1:0] m21,
   input  logic signed [FIELD_W-1:0] m02,
   input  logic signed [FIELD_W-1:0] m12,
   input  logic signed [FIELD_W-1:0] m22,
   output front_word_type            word
);
   localparam logic signed [ARG_W-1:0] ONE_A = ARG_W'(64'sd1 <<< FRAC_BITS);

   logic signed [ARG_W-1:0] e00, e11, e22, tr, arg;
   logic signed [SUM_W-1:0] d_x0, d_y0, d_z0, s_xy, s_xz, s_yz;
   logic signed [SUM_W-1:0] d [LANES];
   logic [1:0] br;

   assign e00 = ARG_W'(m00);
   assign e11 = ARG_W'(m11);
   assign e22 = ARG_W'(m22);
   assign tr  = e00 + e11 + e22;

   assign d_x0 = SUM_W'(m21) - SUM_W'(m12);
   assign d_y0 = SUM_W'(m02) - SUM_W'(m20);
   assign d_z0 = SUM_W'(m10) - SUM_W'(m01);
   assign s_xy = SUM_W'(m01) + SUM_W'(m10);
   assign s_xz = SUM_W'(m02) + SUM_W'(m20);
   assign s_yz = SUM_W'(m12) + SUM_W'(m21);

   always_comb begin
      if (tr > 0) begin
         br = BR_TRACE;
      end else if (m00 > m11 && m00 > m22) begin
         br = BR_M00;
      end else if (m11 > m22) begin
         br = BR_M11;
      end else begin
         br = BR_M22;
      end
      // lanes fill the non-main slots in w, x, y, z order
      unique case (br)
         BR_TRACE: begin
            arg = ONE_A + tr;
            d[0] = d_x0; d[1] = d_y0; d[2] = d_z0;
         end
         BR_M00: begin
            arg = ONE_A + e00 - e11 - e22;
            d[0] = d_x0; d[1] = s_xy; d[2] = s_xz;
         end
         BR_M11: begin
            arg = ONE_A + e11 - e00 - e22;
            d[0] = d_y0; d[1] = s_xy; d[2] = s_yz;
         end
         default: begin
            arg = ONE_A + e22 - e00 - e11;
            d[0] = d_z0; d[1] = s_xz; d[2] = s_yz;
         end
      endcase
      word.br  = br;
      word.bad = (arg <= 0);
      word.arg = arg[ARG_W-2:0];
      for (int j = 0; j < LANES; j++) begin
         word.dneg[j] = d[j][SUM_W-1];
         word.dmag[j] = d[j][SUM_W-1] ? D_MAG_W'(-d[j]) : D_MAG_W'(d[j]);
      end
   end
endmodule

FILE: src/rmq_fifo.sv
// Two-entry queue between the front end and the arithmetic pipeline.
`timescale 1ns / 1ps
module rmq_fifo import rmq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  front_word_type push_word,
   output logic           full,
   input  logic           pop,
   output logic           not_empty,
   output front_word_type pop_word
);
   front_word_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_word  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wp_ff <= ~wp_ff;
         if (do_pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end
endmodule

FILE: src/rmq_back.sv
// Back end: pipelined square root, three pipelined dividers and the output register.
`timescale 1ns / 1ps
module rmq_back import rmq_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  front_word_type            in_word,
   output logic                      in_pop,
   output logic                      out_valid,
   input  logic                      out_stall,
   output logic signed [FIELD_W-1:0] qx,
   output logic signed [FIELD_W-1:0] qy,
   output logic signed [FIELD_W-1:0] qz,
   output logic signed [FIELD_W-1:0] qw,
   output logic [1:0]                br,
   output logic                      bad
);
   stage_type stg_ff [NST];
   stage_type stg_in [NST];
   logic [NST-1:0] vld_ff;
   logic adv;
   logic out_valid_ff;
   logic signed [FIELD_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [FIELD_W-1:0] qx_in, qy_in, qz_in, qw_in;
   logic [1:0] br_ff;
   logic bad_ff;
   logic signed [FIELD_W-1:0] lane [LANES];
   logic signed [FIELD_W-1:0] mainv;

   function automatic stage_type sqrt_step(stage_type a);
      stage_type o;
      logic [REM_W-1:0] remx, trial;
      o = a;
      remx  = {a.rem[REM_W-3:0], a.rad[RAD2_W-1 -: 2]};
      trial = REM_W'({a.root, 2'b01});
      if (remx >= trial) begin
         o.rem  = remx - trial;
         o.root = {a.root[SQ_N-2:0], 1'b1};
      end else begin
         o.rem  = remx;
         o.root = {a.root[SQ_N-2:0], 1'b0};
      end
      o.rad = a.rad << 2;
      return o;
   endfunction

   function automatic stage_type round_step(stage_type a);
      stage_type o;
      logic [S_W-1:0] s, m;
      logic [CMP_W-1:0] num, lim;
      o = a;
      s = S_W'(a.root) + S_W'(a.rem > REM_W'(a.root));
      m = (s + S_W'(2)) >> 2;
      o.s = s;
      o.mainc = (m > S_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX) : FIELD_W'(m);
      lim = CMP_W'(s) << Q_W;
      for (int j = 0; j < LANES; j++) begin
         num = (CMP_W'(a.dmag[j]) << FRAC_BITS) + CMP_W'(s >> 1);
         o.r[j]   = num;
         o.ovf[j] = (num >= lim);
         o.q[j]   = '0;
      end
      return o;
   endfunction

   function automatic stage_type div_step(stage_type a, int k);
      stage_type o;
      logic [CMP_W-1:0] sh;
      o = a;
      sh = CMP_W'(a.s) << k;
      for (int j = 0; j < LANES; j++) begin
         if (!a.ovf[j] && a.r[j] >= sh) begin
            o.r[j]    = a.r[j] - sh;
            o.q[j][k] = 1'b1;
         end
      end
      return o;
   endfunction

   assign adv    = !out_valid_ff || !out_stall;
   assign in_pop = adv && in_valid;

   always_comb begin
      stg_in[0]      = '0;
      stg_in[0].br   = in_word.br;
      stg_in[0].bad  = in_word.bad;
      stg_in[0].rad  = RAD2_W'(in_word.arg) << (FRAC_BITS + 2);
      stg_in[0].dneg = in_word.dneg;
      stg_in[0].dmag = in_word.dmag;
      for (int i = 0; i < NST - 1; i++) begin
         if (i < SQ_N) begin
            stg_in[i+1] = sqrt_step(stg_ff[i]);
         end else if (i == SQ_N) begin
            stg_in[i+1] = round_step(stg_ff[i]);
         end else begin
            stg_in[i+1] = div_step(stg_ff[i], Q_W - 1 - (i - SQ_N - 1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NST; i++) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   // saturate each lane, give it the sign of its sum, route by branch, zero a non-rotation word
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         if (stg_ff[NST-1].ovf[j] || stg_ff[NST-1].q[j][Q_W-1]) begin
            lane[j] = stg_ff[NST-1].dneg[j] ? FIELD_MIN : FIELD_MAX;
         end else if (stg_ff[NST-1].dneg[j]) begin
            lane[j] = -$signed(stg_ff[NST-1].q[j]);
         end else begin
            lane[j] = $signed(stg_ff[NST-1].q[j]);
         end
      end
      mainv = $signed(stg_ff[NST-1].mainc);
      case (stg_ff[NST-1].br)
         BR_TRACE: begin qw_in = mainv;   qx_in = lane[0]; qy_in = lane[1]; qz_in = lane[2]; end
         BR_M00:   begin qw_in = lane[0]; qx_in = mainv;   qy_in = lane[1]; qz_in = lane[2]; end
         BR_M11:   begin qw_in = lane[0]; qx_in = lane[1]; qy_in = mainv;   qz_in = lane[2]; end
         default:  begin qw_in = lane[0]; qx_in = lane[1]; qy_in = lane[2]; qz_in = mainv;   end
      endcase
      if (stg_ff[NST-1].bad) begin
         qx_in = '0; qy_in = '0; qz_in = '0; qw_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff  <= qx_in;
         qy_ff  <= qy_in;
         qz_ff  <= qz_in;
         qw_ff  <= qw_in;
         br_ff  <= stg_ff[NST-1].br;
         bad_ff <= stg_ff[NST-1].bad;
      end
   end

   assign out_valid = out_valid_ff;
   assign qx  = qx_ff;
   assign qy  = qy_ff;
   assign qz  = qz_ff;
   assign qw  = qw_ff;
   assign br  = br_ff;
   assign bad = bad_ff;
endmodule

FILE: src/rotation_matrix_to_quaternion_unit.sv
// Top level of the rotation matrix to quaternion unit.
`timescale 1ns / 1ps
// Converts one 3x3 rotation matrix per word (Q1.16 columns) into a unit quaternion
// using Shepperd's four-branch method. One word is accepted every clock cycle
// while req_stall is low; each result passes the entry register, 19 square-root steps,
// one rounding step, 18 divide steps and the output register, a depth set by the
// one-bit-per-stage square root and the three parallel one-bit-per-stage dividers.
// A two-word queue separates the classifying front end from the arithmetic pipeline,
// so req_stall rises only once the pipeline is held by rsp_stall and the queue fills.
// When the root argument is not positive, the four components read zero and
// rsp_not_rotation is set; rsp_branch_taken still reports the chosen branch.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [FIELD_W-1:0] req_col_u_x,
   input  logic signed [FIELD_W-1:0] req_col_u_y,
   input  logic signed [FIELD_W-1:0] req_col_u_z,
   input  logic signed [FIELD_W-1:0] req_col_v_x,
   input  logic signed [FIELD_W-1:0] req_col_v_y,
   input  logic signed [FIELD_W-1:0] req_col_v_z,
   input  logic signed [FIELD_W-1:0] req_col_n_x,
   input  logic signed [FIELD_W-1:0] req_col_n_y,
   input  logic signed [FIELD_W-1:0] req_col_n_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [FIELD_W-1:0] rsp_quat_x,
   output logic signed [FIELD_W-1:0] rsp_quat_y,
   output logic signed [FIELD_W-1:0] rsp_quat_z,
   output logic signed [FIELD_W-1:0] rsp_quat_w,
   output logic [1:0]                rsp_branch_taken,
   output logic                      rsp_not_rotation
);
   front_word_type fw, qw;
   logic full, not_empty, pop;

   rmq_front u_front (
      .m00(req_col_u_x), .m10(req_col_u_y), .m20(req_col_u_z),
      .m01(req_col_v_x), .m11(req_col_v_y), .m21(req_col_v_z),
      .m02(req_col_n_x), .m12(req_col_n_y), .m22(req_col_n_z),
      .word(fw)
   );

   rmq_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(req_valid), .push_word(fw), .full(full),
      .pop(pop), .not_empty(not_empty), .pop_word(qw)
   );

   assign req_stall = full;

   rmq_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(not_empty), .in_word(qw), .in_pop(pop),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .qx(rsp_quat_x), .qy(rsp_quat_y), .qz(rsp_quat_z), .qw(rsp_quat_w),
      .br(rsp_branch_taken), .bad(rsp_not_rotation)
   );
endmodule

FILE: src/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion unit, bound to the top level.
`timescale 1ns / 1ps
module rmq_checker import rmq_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic signed [FIELD_W-1:0] req_col_u_x,
   input logic signed [FIELD_W-1:0] req_col_u_y,
   input logic signed [FIELD_W-1:0] req_col_u_z,
   input logic signed [FIELD_W-1:0] req_col_v_x,
   input logic signed [FIELD_W-1:0] req_col_v_y,
   input logic signed [FIELD_W-1:0] req_col_v_z,
   input logic signed [FIELD_W-1:0] req_col_n_x,
   input logic signed [FIELD_W-1:0] req_col_n_y,
   input logic signed [FIELD_W-1:0] req_col_n_z,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [FIELD_W-1:0] rsp_quat_x,
   input logic signed [FIELD_W-1:0] rsp_quat_y,
   input logic signed [FIELD_W-1:0] rsp_quat_z,
   input logic signed [FIELD_W-1:0] rsp_quat_w,
   input logic [1:0]                rsp_branch_taken,
   input logic                      rsp_not_rotation
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_x) && $stable(rsp_quat_y)
         && $stable(rsp_quat_z) && $stable(rsp_quat_w) && $stable(rsp_branch_taken)
         && $stable(rsp_not_rotation))
      else $error("result word changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("handshake active after reset");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_rotation |-> rsp_quat_x == 0 && rsp_quat_y == 0
         && rsp_quat_z == 0 && rsp_quat_w == 0)
      else $error("non-rotation word carries nonzero components");

   a_main: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_not_rotation |->
         (rsp_branch_taken == BR_TRACE && rsp_quat_w > 0)
         || (rsp_branch_taken == BR_M00 && rsp_quat_x > 0)
         || (rsp_branch_taken == BR_M11 && rsp_quat_y > 0)
         || (rsp_branch_taken == BR_M22 && rsp_quat_z > 0))
      else $error("main component of branch not positive");
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (.*);

FILE: sim/tb_top.sv
// Testbench for the rotation matrix to quaternion unit: random and directed matrices, scored.
`timescale 1ns / 1ps
module tb_top;
   import rmq_pkg::*;

   typedef logic signed [FIELD_W-1:0] fld_type;

   typedef struct {
      fld_type    qx, qy, qz, qw;
      logic [1:0] br;
      logic       bad;
   } quat_word_type;

   class quat_scoreboard;
      quat_word_type pending[$];
      int            errors;
      int            checked;
      int            nonrot;

      // integer square root, rounded to nearest
      function automatic longint unsigned root_round(longint unsigned n);
         longint unsigned res, b, x;
         res = 0;
         b = 64'd1 << 62;
         x = n;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         if (x > res) res++;
         return res;
      endfunction

      function automatic longint div_round(longint d, longint unsigned s);
         longint unsigned mag, q;
         mag = (d < 0) ? longint'(-d) : longint'(d);
         q = ((mag << FRAC_BITS) + (s >> 1)) / s;
         return (d < 0) ? -longint'(q) : longint'(q);
      endfunction

      function automatic fld_type sat(longint v);
         if (v > 131071) return fld_type'(131071);
         if (v < -131072) return fld_type'(-131072);
         return fld_type'(v);
      endfunction

      function void note_matrix(fld_type m[9]);
         longint a00, a10, a20, a01, a11, a21, a02, a12, a22, tr, arg, mc;
         longint qx, qy, qz, qw;
         longint unsigned s;
         quat_word_type w;
         a00 = m[0]; a10 = m[1]; a20 = m[2];
         a01 = m[3]; a11 = m[4]; a21 = m[5];
         a02 = m[6]; a12 = m[7]; a22 = m[8];
         tr = a00 + a11 + a22;
         if (tr > 0) begin
            w.br = BR_TRACE; arg = (64'sd1 << FRAC_BITS) + tr;
         end else if (a00 > a11 && a00 > a22) begin
            w.br = BR_M00; arg = (64'sd1 << FRAC_BITS) + a00 - a11 - a22;
         end else if (a11 > a22) begin
            w.br = BR_M11; arg = (64'sd1 << FRAC_BITS) + a11 - a00 - a22;
         end else begin
            w.br = BR_M22; arg = (64'sd1 << FRAC_BITS) + a22 - a00 - a11;
         end
         w.bad = (arg <= 0);
         w.qx = '0; w.qy = '0; w.qz = '0; w.qw = '0;
         if (!w.bad) begin
            s = root_round(longint'(arg) << (FRAC_BITS + 2));
            mc = longint'((s + 2) >> 2);
            case (w.br)
               BR_TRACE: begin
                  qw = mc; qx = div_round(a21 - a12, s);
                  qy = div_round(a02 - a20, s); qz = div_round(a10 - a01, s);
               end
               BR_M00: begin
                  qx = mc; qw = div_round(a21 - a12, s);
                  qy = div_round(a01 + a10, s); qz = div_round(a02 + a20, s);
               end
               BR_M11: begin
                  qy = mc; qw = div_round(a02 - a20, s);
                  qx = div_round(a01 + a10, s); qz = div_round(a12 + a21, s);
               end
               default: begin
                  qz = mc; qw = div_round(a10 - a01, s);
                  qx = div_round(a02 + a20, s); qy = div_round(a12 + a21, s);
               end
            endcase
            w.qx = sat(qx); w.qy = sat(qy); w.qz = sat(qz); w.qw = sat(qw);
         end else begin
            nonrot++;
         end
         pending.push_back(w);
      endfunction

      function void check_quat(quat_word_type got);
         quat_word_type e;
         if (pending.size() == 0) begin
            $error("unexpected result word");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.qx !== e.qx) begin
            $error("quat_x exp %0d got %0d", e.qx, got.qx); errors++;
         end
         if (got.qy !== e.qy) begin
            $error("quat_y exp %0d got %0d", e.qy, got.qy); errors++;
         end
         if (got.qz !== e.qz) begin
            $error("quat_z exp %0d got %0d", e.qz, got.qz); errors++;
         end
         if (got.qw !== e.qw) begin
            $error("quat_w exp %0d got %0d", e.qw, got.qw); errors++;
         end
         if (got.br !== e.br) begin
            $error("branch_taken exp %0d got %0d", e.br, got.br); errors++;
         end
         if (got.bad !== e.bad) begin
            $error("not_rotation exp %0d got %0d", e.bad, got.bad); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   fld_type req_m[9];
   logic rsp_valid;
   logic rsp_stall = 0;
   fld_type rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic [1:0] rsp_branch_taken;
   logic rsp_not_rotation;

   quat_scoreboard sb = new();
   longint cycles = 0;
   bit hold_long = 0;
   bit sending_done = 0;

   initial foreach (req_m[i]) req_m[i] = '0;

   always #10 clock = ~clock;

   rotation_matrix_to_quaternion_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_col_u_x(req_m[0]), .req_col_u_y(req_m[1]), .req_col_u_z(req_m[2]),
      .req_col_v_x(req_m[3]), .req_col_v_y(req_m[4]), .req_col_v_z(req_m[5]),
      .req_col_n_x(req_m[6]), .req_col_n_y(req_m[7]), .req_col_n_z(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_quat_w(rsp_quat_w), .rsp_branch_taken(rsp_branch_taken),
      .rsp_not_rotation(rsp_not_rotation)
   );

   // monitors: sample both handshakes at the edge
   always @(posedge clock) begin
      quat_word_type got;
      cycles <= cycles + 1;
      if (!reset && req_valid && !req_stall) sb.note_matrix(req_m);
      if (!reset && rsp_valid && !rsp_stall) begin
         got.qx = rsp_quat_x; got.qy = rsp_quat_y; got.qz = rsp_quat_z;
         got.qw = rsp_quat_w; got.br = rsp_branch_taken; got.bad = rsp_not_rotation;
         sb.check_quat(got);
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int mode;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            hold_long = 0;
         end
         mode = sending_done ? 0 : $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            case (mode)
               0: rsp_stall <= 0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 4) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic fld_type rnd_full();
      return fld_type'($urandom);
   endfunction

   function automatic fld_type rnd_unit();
      return fld_type'($urandom_range(0, 131072) - 65536);
   endfunction

   // offer one matrix; valid stays high into the next word when back to back
   task automatic send_matrix(fld_type m[9]);
      req_valid <= 1;
      foreach (m[i]) req_m[i] <= m[i];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // near-rotation: small perturbation of a signed axis permutation
   function automatic void rot_like(ref fld_type m[9]);
      int p, sgn[3];
      int perm[6][3] = '{'{0,1,2},'{0,2,1},'{1,0,2},'{1,2,0},'{2,0,1},'{2,1,0}};
      p = $urandom_range(0, 5);
      foreach (sgn[i]) sgn[i] = $urandom_range(0, 1) ? 1 : -1;
      for (int c = 0; c < 3; c++)
         for (int r = 0; r < 3; r++)
            m[c*3+r] = fld_type'((perm[p][c] == r ? sgn[c] * 65536 : 0)
                      + int'($urandom_range(0, 30000)) - 15000);
   endfunction

   initial begin
      fld_type m[9];
      int      burst;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: identity, each branch, extremes, not-a-rotation
      foreach (m[i]) m[i] = 0;
      m[0] = 65536; m[4] = 65536; m[8] = 65536; send_matrix(m);
      m[0] = 65536; m[4] = -65536; m[8] = -65536; send_matrix(m);
      m[0] = -65536; m[4] = 65536; m[8] = -65536; send_matrix(m);
      m[0] = -65536; m[4] = -65536; m[8] = 65536; send_matrix(m);
      foreach (m[i]) m[i] = 0; send_matrix(m);
      foreach (m[i]) m[i] = fld_type'(131071); send_matrix(m);
      foreach (m[i]) m[i] = fld_type'(-131072); send_matrix(m);
      foreach (m[i]) m[i] = 0;
      m[0] = -131072; m[4] = -131072; m[8] = -131072; send_matrix(m);
      m[0] = 131071; m[4] = 131071; m[8] = 131071; send_matrix(m);
      // ties among diagonal entries with non-positive trace
      foreach (m[i]) m[i] = 0;
      m[0] = -100; m[4] = -100; m[8] = -100; send_matrix(m);
      m[0] = 0; m[4] = 0; m[8] = -5; send_matrix(m);
      // huge off-diagonals with extreme diagonal entries
      foreach (m[i]) m[i] = fld_type'(131071);
      m[0] = -131072; m[4] = 65535; m[8] = 1; m[1] = -131072; send_matrix(m);
      foreach (m[i]) m[i] = fld_type'(-131072);
      m[0] = -65536; m[4] = -65536; m[8] = 131071; m[5] = 131071; send_matrix(m);
      m[4] = -131072; m[8] = 131071; m[0] = 65536; send_matrix(m);
      idle_gap(3);

      // long receiver hold-off while the sender keeps going
      hold_long = 1;
      for (int k = 0; k < 120; k++) begin
         rot_like(m);
         send_matrix(m);
      end

      for (int n = 0; n < 1200;) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst; k++, n++) begin
            case ($urandom_range(0, 9))
               0, 1: foreach (m[i]) m[i] = rnd_full();
               2, 3: foreach (m[i]) m[i] = rnd_unit();
               default: rot_like(m);
            endcase
            send_matrix(m);
         end
         idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
      end
      req_valid <= 0;
      sending_done = 1;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("checked %0d quaternion words, %0d flagged as not a rotation",
               sb.checked, sb.nonrot);
      if (sb.errors == 0)
         $display("rotation_matrix_to_quaternion_unit: match");
      else
         $display("rotation_matrix_to_quaternion_unit: mismatch");
      $finish;
   end

   initial begin
      wait (cycles > 200000);
      $display("timeout after %0d cycles", cycles);
      $display("rotation_matrix_to_quaternion_unit: mismatch");
      $finish;
   end
endmodule

FILE: rotation_matrix_to_quaternion_unit.f
src/rmq_pkg.sv
src/rmq_front.sv
src/rmq_fifo.sv
src/rmq_back.sv
src/rotation_matrix_to_quaternion_unit.sv
src/rmq_checker.sv
sim/tb_top.sv
